@@ design/fpn2d_pkg.sv @@
// Shared types, codes and the power table generator for the 2D noise unit.
`timescale 1ns / 1ps

package fpn2d_pkg;

  // Item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  // Table components
  localparam logic [1:0] COMP_GX   = 2'd0;
  localparam logic [1:0] COMP_GY   = 2'd1;
  localparam logic [1:0] COMP_OFS  = 2'd2;
  localparam logic [1:0] COMP_NONE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_WEIGHT_GX  = 2'd0;
  localparam logic [1:0] REG_WEIGHT_GY  = 2'd1;
  localparam logic [1:0] REG_WEIGHT_OFS = 2'd2;

  localparam logic [15:0] WEIGHT_RESET = 16'd16384;

  // Exponent 4.67970975809363: integer part and Q.16 fraction
  localparam int          POW_INT  = 4;
  localparam logic [15:0] POW_FRAC = 16'd44545;

  localparam int ENTRY_W = 19;  // stored gradient entry, signed Q3.16
  localparam int DIGIT_W = 3;   // grid phase digit, below OVERLAP <= 8

  // Command from the front to the back; cell indexes travel beside it
  typedef struct packed {
    logic                      kind;   // MODE_WRITE or MODE_EVAL
    logic [1:0]                comp;
    logic signed [ENTRY_W-1:0] data;
    logic [DIGIT_W-1:0]        qx;     // unit step of x inside the grid cell
    logic [15:0]               lox;    // fraction of x
    logic [DIGIT_W-1:0]        qy;
    logic [15:0]               loy;
  } fpn2d_cmd_t;

  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    longint unsigned rem;
    root = 0;
    bitv = 64'd1 << 62;
    rem  = n;
    for (int it = 0; it < 32; it++) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // t^S in Q.16 for t = k / 2^bits, built from repeated square roots
  function automatic logic [16:0] power_entry(input int k, input int bits);
    longint unsigned t;
    longint unsigned res;
    longint unsigned s;
    longint unsigned rnd;
    t   = longint'(k) << (30 - bits);
    res = 64'd1 << 30;
    s   = t;
    for (int n = 0; n < POW_INT; n++) begin
      res = (res * t) >> 30;
    end
    for (int b = 15; b >= 0; b--) begin
      s = isqrt(s << 30);
      if (POW_FRAC[b]) begin
        res = (res * s) >> 30;
      end
    end
    rnd = (res + 64'd8192) >> 14;
    return rnd[16:0];
  endfunction

endpackage

@@ design/fpn2d_item_if.sv @@
// Input channel: valid/ready handshake with the write or evaluate payload.
`timescale 1ns / 1ps

interface fpn2d_item_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;
  logic [1:0]         table_component;
  logic [5:0]         table_row;
  logic [5:0]         table_column;
  logic signed [15:0] table_value;

  modport source (output valid, mode, x_coord, y_coord, table_component, table_row,
                  table_column, table_value, input ready);
  modport sink (input valid, mode, x_coord, y_coord, table_component, table_row,
                table_column, table_value, output ready);
endinterface

@@ design/fpn2d_result_if.sv @@
// Output channel: valid/ready handshake with the noise result.
`timescale 1ns / 1ps

interface fpn2d_result_if;
  logic               valid;
  logic               ready;
  logic signed [24:0] noise_value;
  logic               saturated;

  modport source (output valid, noise_value, saturated, input ready);
  modport sink (input valid, noise_value, saturated, output ready);
endinterface

@@ design/fpn2d_front.sv @@
// Front end: accepts items, scales table writes, locates the grid cells of a point.
`timescale 1ns / 1ps

module fpn2d_front #(
  parameter int TILE_COLUMNS = 64,
  parameter int TILE_ROWS    = 64,
  parameter int OVERLAP      = 4,
  localparam int CW = $clog2(TILE_COLUMNS),
  localparam int RW = $clog2(TILE_ROWS)
) (
  input  logic                   clk,
  input  logic                   rst,
  fpn2d_item_if.sink             item,
  input  logic [15:0]            weight_gx,
  input  logic [15:0]            weight_gy,
  input  logic [15:0]            weight_ofs,
  output logic                   push_valid,
  input  logic                   push_ready,
  output fpn2d_pkg::fpn2d_cmd_t  push_cmd,
  output logic [CW-1:0]          push_gx,
  output logic [RW-1:0]          push_gy
);
  import fpn2d_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_REM   = 3'd3;
  localparam logic [2:0] ST_MODM  = 3'd4;
  localparam logic [2:0] ST_MODS  = 3'd5;
  localparam logic [2:0] ST_PUSH  = 3'd6;

  // Floor division of the integer part by OVERLAP through a biased reciprocal
  localparam int     KO_C   = (32768 + OVERLAP - 1) / OVERLAP;
  localparam int     KO     = OVERLAP * KO_C;
  localparam longint M_O_L  = ((longint'(1) << 20) + OVERLAP - 1) / OVERLAP;
  localparam logic [20:0] M_O = 21'(M_O_L);
  // Cell wrap: bias to a multiple of the tile size, then reciprocal remainder
  localparam int BTX  = TILE_COLUMNS * ((KO + TILE_COLUMNS - 1) / TILE_COLUMNS);
  localparam int BTY  = TILE_ROWS * ((KO + TILE_ROWS - 1) / TILE_ROWS);
  localparam logic [17:0] OFSX = 18'(BTX - KO);
  localparam logic [17:0] OFSY = 18'(BTY - KO);
  localparam longint M_TX_L = ((longint'(1) << 28) + TILE_COLUMNS - 1) / TILE_COLUMNS;
  localparam longint M_TY_L = ((longint'(1) << 28) + TILE_ROWS - 1) / TILE_ROWS;
  localparam logic [27:0] M_TX = 28'(M_TX_L);
  localparam logic [27:0] M_TY = 28'(M_TY_L);

  logic [2:0] state;

  logic                mode_r;
  logic signed [31:0]  x_r, y_r;
  logic [1:0]          comp_r;
  logic [RW-1:0]       row_r;
  logic [CW-1:0]       col_r;
  logic signed [15:0]  val_r;
  logic signed [ENTRY_W-1:0] data_r;
  logic [16:0]         ux, uy, qdx, qdy;
  logic [DIGIT_W-1:0]  remx, remy;
  logic [17:0]         vx, vy, qtx, qty;
  logic [CW-1:0]       gx_r;
  logic [RW-1:0]       gy_r;

  // Small wrap tables for the 6-bit write indexes
  logic [RW-1:0] row_wrap [64];
  logic [CW-1:0] col_wrap [64];
  for (genvar g = 0; g < 64; g++) begin : g_wrap
    localparam int RV = g % TILE_ROWS;
    localparam int CV = g % TILE_COLUMNS;
    assign row_wrap[g] = RV[RW-1:0];
    assign col_wrap[g] = CV[CW-1:0];
  end

  logic [15:0]         wsel;
  logic signed [32:0]  wprod;
  logic signed [33:0]  wround;
  logic [17:0]         sumx, sumy;
  logic [37:0]         pqx, pqy;
  logic [16:0]         qox, qoy, rdx, rdy;
  logic [45:0]         ptx, pty;
  logic [17:0]         mtx, mty, gfx, gfy;

  always_comb begin
    case (comp_r)
      COMP_GX: wsel = weight_gx;
      COMP_GY: wsel = weight_gy;
      default: wsel = weight_ofs;
    endcase
    wprod  = val_r * $signed({1'b0, wsel});
    wround = 34'(wprod) + 34'sd4096;

    sumx = {{2{x_r[31]}}, x_r[31:16]} + 18'(KO);
    sumy = {{2{y_r[31]}}, y_r[31:16]} + 18'(KO);
    pqx  = 38'(sumx[16:0]) * 38'(M_O);
    pqy  = 38'(sumy[16:0]) * 38'(M_O);

    qox = 17'(qdx * OVERLAP);
    qoy = 17'(qdy * OVERLAP);
    rdx = ux - qox;
    rdy = uy - qoy;

    ptx = 46'(vx) * 46'(M_TX);
    pty = 46'(vy) * 46'(M_TY);

    mtx = 18'(qtx * TILE_COLUMNS);
    mty = 18'(qty * TILE_ROWS);
    gfx = vx - mtx;
    gfy = vy - mty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            if (item.mode == MODE_EVAL) begin
              state <= ST_DIV;
            end else if (item.table_component != COMP_NONE) begin
              state <= ST_SCALE;
            end
          end
        end
        ST_SCALE: state <= ST_PUSH;
        ST_DIV:   state <= ST_REM;
        ST_REM:   state <= ST_MODM;
        ST_MODM:  state <= ST_MODS;
        ST_MODS:  state <= ST_PUSH;
        ST_PUSH: begin
          if (push_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item.valid) begin
      mode_r <= item.mode;
      x_r    <= item.x_coord;
      y_r    <= item.y_coord;
      comp_r <= item.table_component;
      row_r  <= row_wrap[item.table_row];
      col_r  <= col_wrap[item.table_column];
      val_r  <= item.table_value;
    end
    if (state == ST_SCALE) begin
      data_r <= wround[ENTRY_W+12:13];
      gx_r   <= col_r;
      gy_r   <= row_r;
    end
    if (state == ST_DIV) begin
      ux  <= sumx[16:0];
      uy  <= sumy[16:0];
      qdx <= pqx[36:20];
      qdy <= pqy[36:20];
    end
    if (state == ST_REM) begin
      remx <= rdx[DIGIT_W-1:0];
      remy <= rdy[DIGIT_W-1:0];
      vx   <= 18'(qox) + OFSX;
      vy   <= 18'(qoy) + OFSY;
    end
    if (state == ST_MODM) begin
      qtx <= ptx[45:28];
      qty <= pty[45:28];
    end
    if (state == ST_MODS) begin
      gx_r <= gfx[CW-1:0];
      gy_r <= gfy[RW-1:0];
    end
  end

  assign item.ready = (state == ST_IDLE);
  assign push_valid = (state == ST_PUSH);

  always_comb begin
    push_cmd.kind = mode_r;
    push_cmd.comp = comp_r;
    push_cmd.data = data_r;
    push_cmd.qx   = remx;
    push_cmd.lox  = x_r[15:0];
    push_cmd.qy   = remy;
    push_cmd.loy  = y_r[15:0];
  end
  assign push_gx = gx_r;
  assign push_gy = gy_r;

endmodule

@@ design/fpn2d_queue.sv @@
// Two-entry command queue between the front and the back.
`timescale 1ns / 1ps

module fpn2d_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/fpn2d_back.sv @@
// Back end: gradient memories, term pipeline, accumulator and result register.
`timescale 1ns / 1ps

module fpn2d_back #(
  parameter int TILE_COLUMNS     = 64,
  parameter int TILE_ROWS        = 64,
  parameter int OVERLAP          = 4,
  parameter int POWER_TABLE_BITS = 10,
  localparam int CW = $clog2(TILE_COLUMNS),
  localparam int RW = $clog2(TILE_ROWS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  fpn2d_pkg::fpn2d_cmd_t pop_cmd,
  input  logic [CW-1:0]         pop_gx,
  input  logic [RW-1:0]         pop_gy,
  fpn2d_result_if.source        result
);
  import fpn2d_pkg::*;

  localparam int DEPTH    = TILE_ROWS * TILE_COLUMNS;
  localparam int AW       = $clog2(DEPTH);
  localparam int IW       = $clog2(OVERLAP);
  localparam int ROM_SIZE = (1 << POWER_TABLE_BITS) + 1;
  localparam int XW       = POWER_TABLE_BITS + 1;
  localparam int SH       = 16 - POWER_TABLE_BITS;
  localparam longint M2_L = ((longint'(1) << 23) + OVERLAP - 1) / OVERLAP;
  localparam logic [22:0] M2 = 23'(M2_L);
  localparam logic [CW:0] DEC_X  = (CW+1)'(TILE_COLUMNS - 1);
  localparam logic [CW:0] WRAP_X = (CW+1)'((OVERLAP - 1) % TILE_COLUMNS);
  localparam logic [RW:0] DEC_Y  = (RW+1)'(TILE_ROWS - 1);
  localparam logic [RW:0] WRAP_Y = (RW+1)'((OVERLAP - 1) % TILE_ROWS);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_RUN   = 2'd1;
  localparam logic [1:0] B_DRAIN = 2'd2;
  localparam logic [1:0] B_DONE  = 2'd3;

  logic [1:0] state;

  // Gradient memories, one per component
  logic signed [ENTRY_W-1:0] mem_gx  [DEPTH];
  logic signed [ENTRY_W-1:0] mem_gy  [DEPTH];
  logic signed [ENTRY_W-1:0] mem_ofs [DEPTH];

  // Power table
  logic [16:0] rom [ROM_SIZE];
  for (genvar k = 0; k < ROM_SIZE; k++) begin : g_rom
    localparam logic [16:0] ENTRY = power_entry(k, POWER_TABLE_BITS);
    assign rom[k] = ENTRY;
  end

  // Walk state over the grids
  logic [IW-1:0]      i_cnt, j_cnt;
  logic [DIGIT_W-1:0] qx0, qx, qy;
  logic [15:0]        lox, loy;
  logic [CW-1:0]      gx0, gx;
  logic [RW-1:0]      gy;
  logic               x_wrap, y_wrap;
  logic [CW:0]        gx_sum;
  logic [RW:0]        gy_sum;
  logic [CW-1:0]      gx_step;
  logic [RW-1:0]      gy_step;
  logic               issue, last_i, last_j;

  logic [AW-1:0] waddr;
  logic          wr_en;

  assign last_i = (i_cnt == IW'(OVERLAP - 1));
  assign last_j = (j_cnt == IW'(OVERLAP - 1));
  assign issue  = (state == B_RUN);
  assign pop_ready = (state == B_IDLE);
  assign wr_en  = pop_valid && pop_ready && (pop_cmd.kind == MODE_WRITE);
  assign waddr  = AW'(int'(pop_gy) * TILE_COLUMNS + int'(pop_gx));

  always_comb begin
    x_wrap = ({1'b0, qx} + 4'd1) == 4'(OVERLAP);
    y_wrap = ({1'b0, qy} + 4'd1) == 4'(OVERLAP);
    gx_sum = {1'b0, gx} + (x_wrap ? WRAP_X : DEC_X);
    gy_sum = {1'b0, gy} + (y_wrap ? WRAP_Y : DEC_Y);
    gx_step = (gx_sum >= (CW+1)'(TILE_COLUMNS)) ? CW'(gx_sum - (CW+1)'(TILE_COLUMNS))
                                                : gx_sum[CW-1:0];
    gy_step = (gy_sum >= (RW+1)'(TILE_ROWS)) ? RW'(gy_sum - (RW+1)'(TILE_ROWS))
                                             : gy_sum[RW-1:0];
  end

  // Pipeline registers
  logic [8:1]                v;
  logic [19:0]               s1_rx2, s1_ry2;
  logic [AW-1:0]             s1_addr;
  logic signed [16:0]        s2_lx, s2_ly;
  logic signed [ENTRY_W-1:0] s2_a, s2_b, s2_c;
  logic [32:0]               s3_sqx, s3_sqy;
  logic signed [35:0]        s3_alx, s3_bly;
  logic signed [ENTRY_W-1:0] s3_c;
  logic [33:0]               s4_w;
  logic signed [37:0]        s4_s, s5_s, s6_s;
  logic [16:0]               s5_lo, s5_hi;
  logic [SH-1:0]             s5_fr;
  logic [16:0]               s6_p;
  logic [35:0]               s7_mlo;
  logic signed [36:0]        s7_mhi;
  logic signed [63:0]        s8_term;
  logic signed [63:0]        acc;

  logic [42:0]        px, py;
  logic [17:0]        lx18, ly18;
  logic [32:0]        wx_full, wy_full;
  logic [16:0]        w17;
  logic [XW-1:0]      idx_lo, idx_hi;
  logic signed [17:0] diff;
  logic signed [SH+18:0] dprod;
  logic signed [SH+18:0] dshift;
  logic [17:0]        p18;

  always_comb begin
    px      = 43'(s1_rx2) * 43'(M2);
    py      = 43'(s1_ry2) * 43'(M2);
    lx18    = 18'(px[42:23]) - 18'd65536;
    ly18    = 18'(py[42:23]) - 18'd65536;
    wx_full = 33'h1_0000_0000 - s3_sqx;
    wy_full = 33'h1_0000_0000 - s3_sqy;
    w17     = s4_w[32:16];
    idx_lo  = w17[16:SH];
    idx_hi  = (idx_lo == XW'(ROM_SIZE - 1)) ? idx_lo : idx_lo + XW'(1);
    diff    = $signed({1'b0, s5_hi}) - $signed({1'b0, s5_lo});
    dprod   = diff * $signed({1'b0, s5_fr});
    dshift  = dprod >>> SH;
    p18     = {1'b0, s5_lo} + dshift[17:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en && pop_cmd.comp == COMP_GX) begin
      mem_gx[waddr] <= pop_cmd.data;
    end
    s2_a <= mem_gx[s1_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en && pop_cmd.comp == COMP_GY) begin
      mem_gy[waddr] <= pop_cmd.data;
    end
    s2_b <= mem_gy[s1_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en && pop_cmd.comp == COMP_OFS) begin
      mem_ofs[waddr] <= pop_cmd.data;
    end
    s2_c <= mem_ofs[s1_addr];
  end

  always_ff @(posedge clk) begin
    s1_rx2  <= {qx, lox, 1'b0};
    s1_ry2  <= {qy, loy, 1'b0};
    s1_addr <= AW'(int'(gy) * TILE_COLUMNS + int'(gx));

    s2_lx <= lx18[16:0];
    s2_ly <= ly18[16:0];

    s3_sqx <= 33'(s2_lx * s2_lx);
    s3_sqy <= 33'(s2_ly * s2_ly);
    s3_alx <= s2_a * s2_lx;
    s3_bly <= s2_b * s2_ly;
    s3_c   <= s2_c;

    s4_w <= 34'(wx_full[32:16]) * 34'(wy_full[32:16]);
    s4_s <= 38'(s3_alx) + 38'(s3_bly) + (38'(s3_c) <<< 16);

    s5_lo <= rom[idx_lo];
    s5_hi <= rom[idx_hi];
    s5_fr <= w17[SH-1:0];
    s5_s  <= s4_s;

    s6_p <= p18[16:0];
    s6_s <= s5_s;

    s7_mlo <= 36'(s6_s[18:0]) * 36'(s6_p);
    s7_mhi <= $signed(s6_s[37:19]) * $signed({1'b0, s6_p});

    s8_term <= ({{27{s7_mhi[36]}}, s7_mhi} <<< 19) + 64'(s7_mlo);
  end

  // Walk control and accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      v     <= '0;
    end else begin
      v <= {v[7:1], issue};
      unique case (state)
        B_IDLE: begin
          if (pop_valid && pop_cmd.kind == MODE_EVAL) begin
            state <= B_RUN;
          end
        end
        B_RUN: begin
          if (last_i && last_j) begin
            state <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          if (v == '0) begin
            state <= B_DONE;
          end
        end
        B_DONE: begin
          if (!result.valid || result.ready) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop_valid) begin
      qx0   <= pop_cmd.qx;
      qx    <= pop_cmd.qx;
      lox   <= pop_cmd.lox;
      qy    <= pop_cmd.qy;
      loy   <= pop_cmd.loy;
      gx0   <= pop_gx;
      gx    <= pop_gx;
      gy    <= pop_gy;
      i_cnt <= '0;
      j_cnt <= '0;
      acc   <= '0;
    end else begin
      if (issue) begin
        if (last_i) begin
          i_cnt <= '0;
          j_cnt <= j_cnt + IW'(1);
          qx    <= qx0;
          gx    <= gx0;
          qy    <= y_wrap ? '0 : qy + DIGIT_W'(1);
          gy    <= gy_step;
        end else begin
          i_cnt <= i_cnt + IW'(1);
          qx    <= x_wrap ? '0 : qx + DIGIT_W'(1);
          gx    <= gx_step;
        end
      end
      if (v[8]) begin
        acc <= acc + s8_term;
      end
    end
  end

  // Rounding, saturation and result register
  logic signed [63:0] acc_rnd;
  logic signed [31:0] total;
  logic               over, under;

  always_comb begin
    acc_rnd = acc + 64'sh8000_0000;
    total   = acc_rnd[63:32];
    over    = total > 32'sd16777215;
    under   = total < -32'sd16777216;
  end

  logic out_valid;
  assign result.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_DONE && (!out_valid || result.ready)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_DONE && (!out_valid || result.ready)) begin
      result.saturated   <= over || under;
      result.noise_value <= over ? 25'sh0FF_FFFF :
                            under ? -25'sh100_0000 : total[24:0];
    end
  end

endmodule

@@ design/fractional_polynomial_noise_2d_unit.sv @@
// Top level of the 2D fractional polynomial noise unit.
// A table write lands in its memory as the idle back end takes it from the queue; an
// evaluate walks OVERLAP*OVERLAP grid cells at one term a cycle, drains the term pipeline
// and then loads the result register; the back end takes the next item only after that.
// Reset clears control state and sets all weights to 1.0; table entries keep
// no reset value and must be written before an evaluate reads them.
`timescale 1ns / 1ps

module fractional_polynomial_noise_2d_unit #(
  parameter int TILE_COLUMNS     = 64,
  parameter int TILE_ROWS        = 64,
  parameter int OVERLAP          = 4,
  parameter int POWER_TABLE_BITS = 10
) (
  input  logic           clk,
  input  logic           rst,
  fpn2d_item_if.sink     item,
  fpn2d_result_if.source result,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import fpn2d_pkg::*;

  localparam int CW = $clog2(TILE_COLUMNS);
  localparam int RW = $clog2(TILE_ROWS);
  localparam int QW = $bits(fpn2d_cmd_t) + CW + RW;

  // Weight registers, applied when a table value is scaled in the front end
  logic [15:0] weight_gx, weight_gy, weight_ofs;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_gx  <= WEIGHT_RESET;
      weight_gy  <= WEIGHT_RESET;
      weight_ofs <= WEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WEIGHT_GX:  weight_gx  <= cfg_data;
        REG_WEIGHT_GY:  weight_gy  <= cfg_data;
        REG_WEIGHT_OFS: weight_ofs <= cfg_data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Front end to queue
  logic       f_valid, f_ready;
  fpn2d_cmd_t f_cmd;
  logic [CW-1:0] f_gx;
  logic [RW-1:0] f_gy;

  fpn2d_front #(
    .TILE_COLUMNS(TILE_COLUMNS),
    .TILE_ROWS   (TILE_ROWS),
    .OVERLAP     (OVERLAP)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .weight_gx (weight_gx),
    .weight_gy (weight_gy),
    .weight_ofs(weight_ofs),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_cmd  (f_cmd),
    .push_gx   (f_gx),
    .push_gy   (f_gy)
  );

  // Queue lets the front locate the next point while the back sums terms
  logic          b_valid, b_ready;
  logic [QW-1:0] b_data;
  fpn2d_cmd_t    b_cmd;
  logic [CW-1:0] b_gx;
  logic [RW-1:0] b_gy;

  fpn2d_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data ({f_cmd, f_gx, f_gy}),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_data  (b_data)
  );

  assign {b_cmd, b_gx, b_gy} = b_data;

  // Back end: memories, term pipeline and result register
  fpn2d_back #(
    .TILE_COLUMNS    (TILE_COLUMNS),
    .TILE_ROWS       (TILE_ROWS),
    .OVERLAP         (OVERLAP),
    .POWER_TABLE_BITS(POWER_TABLE_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_valid(b_valid),
    .pop_ready(b_ready),
    .pop_cmd  (b_cmd),
    .pop_gx   (b_gx),
    .pop_gy   (b_gy),
    .result   (result)
  );

endmodule

@@ design/fpn2d_checker.sv @@
// Port-level checks for the noise unit, bound to the top level.
`timescale 1ns / 1ps

module fpn2d_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [24:0] noise_value,
  input logic        saturated
);

  // Hold a stalled result
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(noise_value)
      && $stable(saturated))
    else $error("result changed while stalled");

  // Clip only to the range ends
  a_sat_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> noise_value == 25'h0FF_FFFF || noise_value == 25'h100_0000)
    else $error("saturated result is not at a range end");

  // Drop any result across reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind fractional_polynomial_noise_2d_unit fpn2d_checker u_fpn2d_checker (
  .clk         (clk),
  .rst         (rst),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .noise_value (result.noise_value),
  .saturated   (result.saturated)
);
